// ===== hdl/kce_pkg.sv =====
// Shared types, codes and defaults of the k-means clustering engine.
`timescale 1ns / 1ps
package kce_pkg;

	localparam int DEF_MAX_POINTS   = 1024;
	localparam int DEF_MAX_DIMS     = 8;
	localparam int DEF_MAX_CLUSTERS = 8;
	localparam int DEF_COORD_BITS   = 16;

	localparam int ITER_W = 16;
	localparam int CFG_W  = 16;
	localparam int NP_W   = 11;
	localparam int ND_W   = 4;
	localparam int NK_W   = 4;

	localparam logic [NP_W-1:0]   RST_NUM_POINTS   = 11'd1024;
	localparam logic [ND_W-1:0]   RST_NUM_DIMS     = 4'd8;
	localparam logic [NK_W-1:0]   RST_NUM_CLUSTERS = 4'd3;
	localparam logic [ITER_W-1:0] RST_MAX_ITER     = 16'd100;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_SEED  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [1:0] REG_NUM_POINTS   = 2'd0;
	localparam logic [1:0] REG_NUM_DIMS     = 2'd1;
	localparam logic [1:0] REG_NUM_CLUSTERS = 2'd2;
	localparam logic [1:0] REG_MAX_ITER     = 2'd3;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEED,
		ST_SEED_END,
		ST_ZERO,
		ST_DIST,
		ST_DWAIT,
		ST_ACC,
		ST_AWAIT,
		ST_UPD_CHK,
		ST_UPD_RD,
		ST_UPD_LD,
		ST_UPD_DIV,
		ST_UPD_WR,
		ST_FIN,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_HOLD
	} state_t;

	typedef struct packed {
		logic take;
		logic seed_rd;
		logic seed_asg;
		logic asg_clr;
		logic zero;
		logic dist_issue;
		logic first;
		logic last;
		logic acc_issue;
		logic upd_rd;
		logic div_start;
		logic upd_wr;
		logic out_rd;
		logic out_load;
		logic out_last;
	} cmd_t;

	typedef struct packed {
		logic changed;
		logic cnt_zero;
		logic div_done;
		logic out_taken;
		logic load_ok;
		logic seed_ok;
	} sts_t;

endpackage

// ===== hdl/kce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;
endmodule

// ===== hdl/kce_div.sv =====
// Restoring divider, one quotient bit per cycle, signed result by magnitude and sign.
`timescale 1ns / 1ps
module kce_div #(
	parameter int DVD_W = 27,
	parameter int DVS_W = 11,
	localparam int CW = $clog2(DVD_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic             neg,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);
	logic [DVD_W-1:0] q_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [DVD_W-1:0] res_q;

	logic [DVS_W:0]   rem_sh;
	logic             qbit;
	logic [DVS_W:0]   rem_diff;
	logic [DVD_W-1:0] q_nx;

	always_comb begin
		rem_sh   = {rem_q, q_q[DVD_W-1]};
		qbit     = rem_sh >= {1'b0, dvs_q};
		rem_diff = rem_sh - {1'b0, dvs_q};
		q_nx     = {q_q[DVD_W-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			q_q   <= q_nx;
			rem_q <= qbit ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			if (cnt_q == CW'(DVD_W - 1)) begin
				res_q <= neg_q ? (~q_nx + 1'b1) : q_nx;
			end
		end
	end

	assign quotient = res_q;
	assign done     = done_q;
endmodule

// ===== hdl/kce_dp.sv =====
// Datapath: point, centre, sum and assignment stores, distance pipe, divider, result register.
`timescale 1ns / 1ps
module kce_dp #(
	parameter int MAX_POINTS   = 1024,
	parameter int MAX_DIMS     = 8,
	parameter int MAX_CLUSTERS = 8,
	parameter int COORD_BITS   = 16,
	localparam int PT_AW  = $clog2(MAX_POINTS),
	localparam int DIM_AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
	localparam int CL_AW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kce_pkg::cmd_t            cmd,
	output kce_pkg::sts_t            sts,
	input  logic [PT_AW-1:0]         p,
	input  logic [CL_AW-1:0]         c,
	input  logic [DIM_AW-1:0]        j,
	input  logic [kce_pkg::ITER_W-1:0] iter,
	input  logic [1:0]               kind,
	input  logic [9:0]               point_index,
	input  logic [2:0]               dim_index,
	input  logic signed [15:0]       value,
	input  logic [2:0]               cluster_index,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               cluster_index_res,
	output logic [2:0]               dim_index_res,
	output logic signed [15:0]       center_value,
	output logic [15:0]              iterations_used,
	output logic                     converged,
	output logic                     last
);
	import kce_pkg::*;

	localparam int CB      = COORD_BITS;
	localparam int SUM_W   = CB + $clog2(MAX_POINTS) + 1;
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int ASG_W   = CL_AW + 1;
	localparam int SQ_W    = 2 * CB + 2;
	localparam int EXT_W   = SQ_W + 4;
	localparam int DIST_W  = (SQ_W + 3 > 64) ? 64 : SQ_W + 3;
	localparam int VW      = (CB > 16) ? CB : 16;
	localparam int PT_DEP  = 1 << (PT_AW + DIM_AW);
	localparam int CT_DEP  = 1 << (CL_AW + DIM_AW);
	localparam logic [ASG_W-1:0] UNASSIGNED = ASG_W'(1) << CL_AW;

	// input capture and range checks
	logic [PT_AW-1:0] seed_pi_q;
	logic [CL_AW-1:0] seed_ci_q;
	logic             load_ok;
	logic             seed_ok;

	assign load_ok = (32'(point_index) < MAX_POINTS) && (32'(dim_index) < MAX_DIMS);
	assign seed_ok = (32'(point_index) < MAX_POINTS) && (32'(cluster_index) < MAX_CLUSTERS);

	always_ff @(posedge clk) begin
		if (cmd.take && kind == KIND_SEED) begin
			seed_pi_q <= PT_AW'(point_index);
			seed_ci_q <= CL_AW'(cluster_index);
		end
	end

	// pipeline control
	logic                dist_s1, first_s1, last_s1, seed_s1, acc_s1;
	logic [CL_AW-1:0]    c_s1;
	logic [DIM_AW-1:0]   j_s1;
	logic                dist_s2, first_s2, last_s2;
	logic [CL_AW-1:0]    c_s2;
	logic [CB:0]         ad_s2;
	logic                dist_s3, first_s3, last_s3;
	logic [CL_AW-1:0]    c_s3;
	logic [SQ_W-1:0]     sq_s3;

	// store ports
	logic [CB-1:0]       pt_rd, ct_rd;
	logic [SUM_W-1:0]    sum_rd;
	logic [ASG_W-1:0]    asg_rd;
	logic [VW-1:0]       val_ext;
	logic [PT_AW+DIM_AW-1:0] pt_raddr;
	logic                ct_we;
	logic [CL_AW+DIM_AW-1:0] ct_waddr;
	logic [CB-1:0]       ct_wdata;
	logic                sum_we;
	logic [CL_AW+DIM_AW-1:0] sum_waddr, sum_raddr;
	logic [SUM_W-1:0]    sum_wdata;
	logic                asg_we;
	logic [PT_AW-1:0]    asg_waddr;
	logic [ASG_W-1:0]    asg_wdata;
	logic                acc_first;

	logic [DIST_W-1:0]   dist_q, best_q;
	logic [CL_AW-1:0]    nc_q;
	logic [CNT_W-1:0]    cnt_q [MAX_CLUSTERS];
	logic                changed_q;
	logic [CNT_W-1:0]    cnt_sel;
	logic [SUM_W-1:0]    div_q;
	logic                div_done;

	assign val_ext   = VW'($unsigned(value));
	assign pt_raddr  = cmd.seed_rd ? {seed_pi_q, j} : {p, j};
	assign acc_first = cmd.acc_issue && cmd.first;

	kce_ram #(.WIDTH(CB), .DEPTH(PT_DEP)) u_point (
		.clk   (clk),
		.we    (cmd.take && kind == KIND_LOAD && load_ok),
		.waddr ({PT_AW'(point_index), DIM_AW'(dim_index)}),
		.wdata (val_ext[CB-1:0]),
		.re    (cmd.seed_rd || cmd.dist_issue || cmd.acc_issue),
		.raddr (pt_raddr),
		.rdata (pt_rd)
	);

	assign ct_we    = seed_s1 || cmd.upd_wr;
	assign ct_waddr = seed_s1 ? {seed_ci_q, j_s1} : {c, j};
	assign ct_wdata = seed_s1 ? pt_rd : div_q[CB-1:0];

	kce_ram #(.WIDTH(CB), .DEPTH(CT_DEP)) u_center (
		.clk   (clk),
		.we    (ct_we),
		.waddr (ct_waddr),
		.wdata (ct_wdata),
		.re    (cmd.dist_issue || cmd.out_rd),
		.raddr ({c, j}),
		.rdata (ct_rd)
	);

	assign sum_we    = cmd.zero || acc_s1;
	assign sum_waddr = acc_s1 ? {nc_q, j_s1} : {c, j};
	assign sum_wdata = acc_s1 ? (sum_rd + SUM_W'($signed(pt_rd))) : '0;
	assign sum_raddr = cmd.acc_issue ? {nc_q, j} : {c, j};

	kce_ram #(.WIDTH(SUM_W), .DEPTH(CT_DEP)) u_sum (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.re    (cmd.acc_issue || cmd.upd_rd),
		.raddr (sum_raddr),
		.rdata (sum_rd)
	);

	always_comb begin
		asg_we    = cmd.asg_clr || cmd.seed_asg || acc_first;
		asg_waddr = p;
		asg_wdata = UNASSIGNED;
		if (cmd.seed_asg) begin
			asg_waddr = seed_pi_q;
			asg_wdata = ASG_W'(seed_ci_q);
		end else if (acc_first) begin
			asg_wdata = ASG_W'(nc_q);
		end
	end

	kce_ram #(.WIDTH(ASG_W), .DEPTH(MAX_POINTS)) u_assign (
		.clk   (clk),
		.we    (asg_we),
		.waddr (asg_waddr),
		.wdata (asg_wdata),
		.re    (cmd.dist_issue),
		.raddr (p),
		.rdata (asg_rd)
	);

	// distance pipe: read, absolute difference, square, accumulate and compare
	logic signed [CB:0]  diff;
	logic [EXT_W-1:0]    tot_ext;
	logic [DIST_W-1:0]   tot;

	assign diff = $signed({ct_rd[CB-1], ct_rd}) - $signed({pt_rd[CB-1], pt_rd});

	always_comb begin
		tot_ext = EXT_W'(sq_s3) + (first_s3 ? '0 : EXT_W'(dist_q));
		tot     = ((tot_ext >> DIST_W) != '0) ? '1 : tot_ext[DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_s1 <= 1'b0;
			seed_s1 <= 1'b0;
			acc_s1  <= 1'b0;
			dist_s2 <= 1'b0;
			dist_s3 <= 1'b0;
		end else begin
			dist_s1 <= cmd.dist_issue;
			seed_s1 <= cmd.seed_rd;
			acc_s1  <= cmd.acc_issue;
			dist_s2 <= dist_s1;
			dist_s3 <= dist_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		c_s1     <= c;
		j_s1     <= j;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		c_s2     <= c_s1;
		ad_s2    <= diff[CB] ? $unsigned(-diff) : $unsigned(diff);
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		c_s3     <= c_s2;
		sq_s3    <= SQ_W'(ad_s2) * SQ_W'(ad_s2);
		if (dist_s3) begin
			dist_q <= tot;
			// ties keep the lower cluster
			if (last_s3 && (c_s3 == '0 || tot < best_q)) begin
				best_q <= tot;
				nc_q   <= c_s3;
			end
		end
	end

	// cluster counts and move flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.zero) begin
			changed_q <= 1'b0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (acc_first) begin
			if (asg_rd != ASG_W'(nc_q)) begin
				changed_q <= 1'b1;
			end
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				if (CL_AW'(i) == nc_q) begin
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

	assign cnt_sel = cnt_q[c];

	kce_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_rd[SUM_W-1] ? (~sum_rd + 1'b1) : sum_rd),
		.neg      (sum_rd[SUM_W-1]),
		.divisor  (cnt_sel),
		.quotient (div_q),
		.done     (div_done)
	);

	// result register
	logic                out_valid_q;
	logic [CL_AW-1:0]    out_c_q;
	logic [DIM_AW-1:0]   out_j_q;
	logic [CB-1:0]       out_val_q;
	logic [ITER_W-1:0]   out_iter_q;
	logic                out_conv_q;
	logic                out_last_q;
	logic [VW-1:0]       cv_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_c_q    <= c;
			out_j_q    <= j;
			out_val_q  <= ct_rd;
			out_iter_q <= iter;
			out_conv_q <= !changed_q;
			out_last_q <= cmd.out_last;
		end
	end

	assign cv_ext            = VW'(out_val_q);
	assign out_valid         = out_valid_q;
	assign cluster_index_res = 3'(out_c_q);
	assign dim_index_res     = 3'(out_j_q);
	assign center_value      = cv_ext[15:0];
	assign iterations_used   = out_iter_q;
	assign converged         = out_conv_q;
	assign last              = out_last_q;

	assign sts.changed   = changed_q;
	assign sts.cnt_zero  = (cnt_sel == '0);
	assign sts.div_done  = div_done;
	assign sts.out_taken = out_valid_q && !out_stall;
	assign sts.load_ok   = load_ok;
	assign sts.seed_ok   = seed_ok;
endmodule

// ===== hdl/kce_ctrl.sv =====
// Controller: configuration registers, sequencing state machine and loop counters.
`timescale 1ns / 1ps
module kce_ctrl #(
	parameter int MAX_POINTS   = 1024,
	parameter int MAX_DIMS     = 8,
	parameter int MAX_CLUSTERS = 8,
	localparam int PT_AW  = $clog2(MAX_POINTS),
	localparam int DIM_AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
	localparam int CL_AW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [kce_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 kind,
	input  kce_pkg::sts_t              sts,
	output kce_pkg::cmd_t              cmd,
	output logic [PT_AW-1:0]           p,
	output logic [CL_AW-1:0]           c,
	output logic [DIM_AW-1:0]          j,
	output logic [kce_pkg::ITER_W-1:0] iter
);
	import kce_pkg::*;

	localparam logic [PT_AW-1:0]  PT_LAST   = PT_AW'(MAX_POINTS - 1);
	localparam logic [DIM_AW-1:0] SEED_LAST = DIM_AW'(MAX_DIMS - 1);

	logic [NP_W-1:0]   num_points_q;
	logic [ND_W-1:0]   num_dims_q;
	logic [NK_W-1:0]   num_clusters_q;
	logic [ITER_W-1:0] max_iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q   <= RST_NUM_POINTS;
			num_dims_q     <= RST_NUM_DIMS;
			num_clusters_q <= RST_NUM_CLUSTERS;
			max_iter_q     <= RST_MAX_ITER;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_POINTS:   num_points_q   <= cfg_data[NP_W-1:0];
				REG_NUM_DIMS:     num_dims_q     <= cfg_data[ND_W-1:0];
				REG_NUM_CLUSTERS: num_clusters_q <= cfg_data[NK_W-1:0];
				REG_MAX_ITER:     max_iter_q     <= cfg_data[ITER_W-1:0];
				default:          ;
			endcase
		end
	end

	// clamp the registers to what the stores hold
	logic [31:0]        n_eff;
	logic [ND_W-1:0]    d_eff;
	logic [NK_W-1:0]    k_eff;
	logic [ITER_W-1:0]  limit;
	logic [DIM_AW-1:0]  d_last;
	logic [CL_AW-1:0]   k_last;
	logic               run_ok, p_last, loop_end, iter_done;

	always_comb begin
		n_eff = (32'(num_points_q) > MAX_POINTS) ? 32'(MAX_POINTS) : 32'(num_points_q);
		if (num_dims_q == '0) begin
			d_eff = ND_W'(1);
		end else if (32'(num_dims_q) > MAX_DIMS) begin
			d_eff = ND_W'(MAX_DIMS);
		end else begin
			d_eff = num_dims_q;
		end
		if (num_clusters_q == '0) begin
			k_eff = NK_W'(1);
		end else if (32'(num_clusters_q) > MAX_CLUSTERS) begin
			k_eff = NK_W'(MAX_CLUSTERS);
		end else begin
			k_eff = num_clusters_q;
		end
		limit     = (max_iter_q == '0) ? ITER_W'(1) : max_iter_q;
		d_last    = DIM_AW'(d_eff - 1'b1);
		k_last    = CL_AW'(k_eff - 1'b1);
		run_ok    = 32'(k_eff) <= n_eff;
		p_last    = 32'(p) == (n_eff - 32'd1);
		loop_end  = (j == d_last) && (c == k_last);
		iter_done = !sts.changed || (iter >= limit);
	end

	state_t state_q, state_nx;
	logic [1:0] w_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR:    if (p == PT_LAST) state_nx = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					case (kind)
						KIND_SEED:  if (sts.seed_ok) state_nx = ST_SEED;
						KIND_START: if (run_ok) state_nx = ST_ZERO;
						default:    state_nx = ST_IDLE;
					endcase
				end
			end
			ST_SEED:     if (j == SEED_LAST) state_nx = ST_SEED_END;
			ST_SEED_END: state_nx = ST_IDLE;
			ST_ZERO:     if (loop_end) state_nx = ST_DIST;
			ST_DIST:     if (loop_end) state_nx = ST_DWAIT;
			ST_DWAIT:    if (w_q == 2'd2) state_nx = ST_ACC;
			ST_ACC:      if (j == d_last) state_nx = ST_AWAIT;
			ST_AWAIT:    state_nx = p_last ? ST_UPD_CHK : ST_DIST;
			ST_UPD_CHK: begin
				if (!sts.cnt_zero) begin
					state_nx = ST_UPD_RD;
				end else if (c == k_last) begin
					state_nx = ST_FIN;
				end
			end
			ST_UPD_RD:   state_nx = ST_UPD_LD;
			ST_UPD_LD:   state_nx = ST_UPD_DIV;
			ST_UPD_DIV:  if (sts.div_done) state_nx = ST_UPD_WR;
			ST_UPD_WR: begin
				if (j != d_last) begin
					state_nx = ST_UPD_RD;
				end else if (c == k_last) begin
					state_nx = ST_FIN;
				end else begin
					state_nx = ST_UPD_CHK;
				end
			end
			ST_FIN:      state_nx = iter_done ? ST_OUT_RD : ST_ZERO;
			ST_OUT_RD:   state_nx = ST_OUT_LD;
			ST_OUT_LD:   state_nx = ST_OUT_HOLD;
			ST_OUT_HOLD: if (sts.out_taken) state_nx = loop_end ? ST_IDLE : ST_OUT_RD;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR:    cmd.asg_clr = 1'b1;
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			ST_SEED:     cmd.seed_rd = 1'b1;
			ST_SEED_END: cmd.seed_asg = 1'b1;
			ST_ZERO:     cmd.zero = 1'b1;
			ST_DIST: begin
				cmd.dist_issue = 1'b1;
				cmd.first      = (j == '0);
				cmd.last       = (j == d_last);
			end
			ST_ACC: begin
				cmd.acc_issue = 1'b1;
				cmd.first     = (j == '0);
			end
			ST_UPD_RD:   cmd.upd_rd = 1'b1;
			ST_UPD_LD:   cmd.div_start = 1'b1;
			ST_UPD_WR:   cmd.upd_wr = 1'b1;
			ST_OUT_RD:   cmd.out_rd = 1'b1;
			ST_OUT_LD: begin
				cmd.out_load = 1'b1;
				cmd.out_last = loop_end;
			end
			default:     ;
		endcase
	end

	// loop counters; the coordinate loop wraps into the cluster loop
	logic [DIM_AW-1:0] adv_j;
	logic [CL_AW-1:0]  adv_c;

	always_comb begin
		adv_j = (j == d_last) ? '0 : j + 1'b1;
		adv_c = c;
		if (j == d_last) begin
			adv_c = (c == k_last) ? '0 : c + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			p       <= '0;
			c       <= '0;
			j       <= '0;
			w_q     <= '0;
			iter    <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_CLEAR:    p <= (p == PT_LAST) ? '0 : p + 1'b1;
				ST_IDLE: begin
					if (in_valid) begin
						p   <= '0;
						c   <= '0;
						j   <= '0;
						w_q <= '0;
						if (kind == KIND_START && run_ok) begin
							iter <= ITER_W'(1);
						end
					end
				end
				ST_SEED:     j <= j + 1'b1;
				ST_ZERO, ST_DIST, ST_UPD_WR: begin
					j <= adv_j;
					c <= adv_c;
				end
				ST_DWAIT:    w_q <= (w_q == 2'd2) ? '0 : w_q + 1'b1;
				ST_ACC:      j <= adv_j;
				ST_AWAIT:    p <= p_last ? '0 : p + 1'b1;
				ST_UPD_CHK:  if (sts.cnt_zero) c <= (c == k_last) ? '0 : c + 1'b1;
				ST_FIN:      if (!iter_done) iter <= iter + 1'b1;
				ST_OUT_HOLD: begin
					if (sts.out_taken) begin
						j <= adv_j;
						c <= adv_c;
					end
				end
				default:     ;
			endcase
		end
	end
endmodule

// ===== hdl/kmeans_clustering_engine.sv =====
// Lloyd k-means clustering engine: top level joining controller and datapath.
//
// Usage: configuration registers are written over cfg_we/cfg_index/cfg_data while the
// engine is idle. Requests arrive on the in channel (in_valid/in_stall). A load request
// (kind 0) writes one coordinate and is taken every cycle while the engine is idle. A seed
// request (kind 1) copies a stored point into a centre. A start request (kind 2) runs the
// iterations and then sends one result per centre coordinate on the out channel
// (out_valid/out_stall), cluster-major, with last on the final one.
// The pace of a start is set by the one read port of the point and centre stores and by
// the bit-serial divider, which runs once for each centre coordinate of a non-empty
// cluster and is SUM_W bits wide (SUM_W is 27 at the default sizes). Each result passes
// through the read, load and hold states.
// in_stall is high for the whole of a seed or a run. A stalled result holds its value
// and the engine waits on it. After reset the assignment store is swept to unassigned,
// one point per cycle over all MAX_POINTS entries, with in_stall high; configuration writes
// are still taken during the sweep.
`timescale 1ns / 1ps
module kmeans_clustering_engine #(
	parameter int MAX_POINTS   = kce_pkg::DEF_MAX_POINTS,
	parameter int MAX_DIMS     = kce_pkg::DEF_MAX_DIMS,
	parameter int MAX_CLUSTERS = kce_pkg::DEF_MAX_CLUSTERS,
	parameter int COORD_BITS   = kce_pkg::DEF_COORD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [kce_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                kind,
	input  logic [9:0]                point_index,
	input  logic [2:0]                dim_index,
	input  logic signed [15:0]        value,
	input  logic [2:0]                cluster_index,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                cluster_index_res,
	output logic [2:0]                dim_index_res,
	output logic signed [15:0]        center_value,
	output logic [15:0]               iterations_used,
	output logic                      converged,
	output logic                      last
);
	import kce_pkg::*;

	localparam int PT_AW  = $clog2(MAX_POINTS);
	localparam int DIM_AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CL_AW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

	cmd_t              cmd;
	sts_t              sts;
	logic [PT_AW-1:0]  p;
	logic [CL_AW-1:0]  c;
	logic [DIM_AW-1:0] j;
	logic [ITER_W-1:0] iter;

	kce_ctrl #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_DIMS     (MAX_DIMS),
		.MAX_CLUSTERS (MAX_CLUSTERS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.sts       (sts),
		.cmd       (cmd),
		.p         (p),
		.c         (c),
		.j         (j),
		.iter      (iter)
	);

	kce_dp #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_DIMS     (MAX_DIMS),
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.COORD_BITS   (COORD_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.p                 (p),
		.c                 (c),
		.j                 (j),
		.iter              (iter),
		.kind              (kind),
		.point_index       (point_index),
		.dim_index         (dim_index),
		.value             (value),
		.cluster_index     (cluster_index),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.cluster_index_res (cluster_index_res),
		.dim_index_res     (dim_index_res),
		.center_value      (center_value),
		.iterations_used   (iterations_used),
		.converged         (converged),
		.last              (last)
	);
endmodule
